// ----- rtl/core/ebc_pkg.sv -----
// Shared types, operation codes and helpers for the 8-bit CPU execute unit.
// No dependencies; every other file in rtl/core imports this package.
`default_nettype none
package ebc_pkg;

	localparam int STACK_AW = 8;
	localparam int STACK_DEPTH = 1 << STACK_AW;
	localparam logic [7:0] SP_RESET = 8'hFD;
	localparam logic [7:0] P_RESET = 8'h24;
	localparam logic [15:0] VECTOR_RESET = 16'h0000;

	// Status bit positions
	localparam int FC = 0;
	localparam int FZ = 1;
	localparam int FI = 2;
	localparam int FD = 3;
	localparam int FB = 4;
	localparam int FU = 5;
	localparam int FV = 6;
	localparam int FN = 7;

	// Operation codes
	localparam logic [5:0] OP_ADC = 6'd0,  OP_AND = 6'd1,  OP_ASL = 6'd2,  OP_BCC = 6'd3;
	localparam logic [5:0] OP_BCS = 6'd4,  OP_BEQ = 6'd5,  OP_BIT = 6'd6,  OP_BMI = 6'd7;
	localparam logic [5:0] OP_BNE = 6'd8,  OP_BPL = 6'd9,  OP_BRK = 6'd10, OP_BVC = 6'd11;
	localparam logic [5:0] OP_BVS = 6'd12, OP_CLC = 6'd13, OP_CLD = 6'd14, OP_CLI = 6'd15;
	localparam logic [5:0] OP_CLV = 6'd16, OP_CMP = 6'd17, OP_CPX = 6'd18, OP_CPY = 6'd19;
	localparam logic [5:0] OP_DEC = 6'd20, OP_DEX = 6'd21, OP_DEY = 6'd22, OP_EOR = 6'd23;
	localparam logic [5:0] OP_INC = 6'd24, OP_INX = 6'd25, OP_INY = 6'd26, OP_JMP = 6'd27;
	localparam logic [5:0] OP_JSR = 6'd28, OP_LDA = 6'd29, OP_LDX = 6'd30, OP_LDY = 6'd31;
	localparam logic [5:0] OP_LSR = 6'd32, OP_NOP = 6'd33, OP_ORA = 6'd34, OP_PHA = 6'd35;
	localparam logic [5:0] OP_PHP = 6'd36, OP_PLA = 6'd37, OP_PLP = 6'd38, OP_ROL = 6'd39;
	localparam logic [5:0] OP_ROR = 6'd40, OP_RTI = 6'd41, OP_RTS = 6'd42, OP_SBC = 6'd43;
	localparam logic [5:0] OP_SEC = 6'd44, OP_SED = 6'd45, OP_SEI = 6'd46, OP_STA = 6'd47;
	localparam logic [5:0] OP_STX = 6'd48, OP_STY = 6'd49, OP_TAX = 6'd50, OP_TAY = 6'd51;
	localparam logic [5:0] OP_TSX = 6'd52, OP_TXA = 6'd53, OP_TXS = 6'd54, OP_TYA = 6'd55;
	localparam logic [5:0] OP_LAX = 6'd56, OP_SAX = 6'd57, OP_DCP = 6'd58, OP_ISB = 6'd59;
	localparam logic [5:0] OP_SLO = 6'd60, OP_RLA = 6'd61, OP_SRE = 6'd62, OP_RRA = 6'd63;

	typedef struct packed {
		logic [5:0]  action;
		logic [7:0]  operand_value;
		logic [15:0] operand_address;
		logic        accumulator_mode;
		logic        page_crossed;
		logic [15:0] next_pc;
	} instr_t;

	typedef struct packed {
		logic        mem_write;
		logic [15:0] mem_address;
		logic [7:0]  mem_data;
		logic [15:0] new_pc;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [7:0]  stack_pointer_out;
		logic [7:0]  flags_out;
		logic        branch_taken;
		logic        extra_page_cycle;
	} result_t;

	typedef struct packed {
		logic [7:0] a;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] s;
		logic [7:0] p;
	} regs_t;

	// Bytes pulled from the stack, oldest first; the last one is the live read data
	typedef struct packed {
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
	} pulled_t;

	// Number of stack pushes for an operation
	function automatic logic [1:0] push_count(input logic [5:0] op);
		unique case (op)
			OP_BRK: push_count = 2'd3;
			OP_JSR: push_count = 2'd2;
			OP_PHA, OP_PHP: push_count = 2'd1;
			default: push_count = 2'd0;
		endcase
	endfunction

	// Number of stack pulls for an operation
	function automatic logic [1:0] pull_count(input logic [5:0] op);
		unique case (op)
			OP_RTI: pull_count = 2'd3;
			OP_RTS: pull_count = 2'd2;
			OP_PLA, OP_PLP: pull_count = 2'd1;
			default: pull_count = 2'd0;
		endcase
	endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ebc_stack_ram.sv -----
// Stack page: 256 x 8 synchronous memory, one write and one registered read port.
// Per-entry valid bits make unwritten entries read as zero after reset. Uses ebc_pkg.
`default_nettype none
module ebc_stack_ram (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         we,
	input  wire logic [ebc_pkg::STACK_AW-1:0] waddr,
	input  wire logic [7:0]                   wdata,
	input  wire logic                         re,
	input  wire logic [ebc_pkg::STACK_AW-1:0] raddr,
	output logic      [7:0]                   rdata
);
	import ebc_pkg::*;

	logic [7:0]             mem [STACK_DEPTH];
	logic [STACK_DEPTH-1:0] valid_q;
	logic [7:0]             rd_q;
	logic                   rvalid_q;

	// Write the array
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Mark written entries
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (we) begin
			valid_q[waddr] <= 1'b1;
		end
	end

	// Register the read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rvalid_q <= 1'b0;
		end else if (re) begin
			rvalid_q <= valid_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign rdata = rvalid_q ? rd_q : 8'h00;

endmodule
`default_nettype wire

// ----- rtl/core/ebc_alu.sv -----
// Final step of one instruction: register, flag, PC and memory-write results.
// Takes the register file, pulled stack bytes and the break vector. Uses ebc_pkg.
`default_nettype none
module ebc_alu (
	input  wire ebc_pkg::instr_t  instr,
	input  wire ebc_pkg::regs_t   regs,
	input  wire ebc_pkg::pulled_t pulled,
	input  wire logic [15:0]      vector,
	output ebc_pkg::regs_t        regs_nx,
	output ebc_pkg::result_t      result
);
	import ebc_pkg::*;

	logic [7:0]  m;
	logic [7:0]  a_sh;
	logic [7:0]  sh_r;
	logic        sh_c;
	logic [7:0]  inc_r;
	logic [7:0]  dec_r;
	logic [7:0]  adc_v;
	logic [7:0]  adc_a;
	logic        adc_cin;
	logic [8:0]  adc_sum;
	logic [7:0]  cmp_reg;
	logic [7:0]  cmp_v;
	logic [8:0]  cmp_diff;
	logic [15:0] pc_lo;
	logic        cond;
	logic        isbr;
	logic [7:0]  nzv;
	logic        set_nz;

	assign m     = instr.operand_value;
	assign inc_r = m + 8'd1;
	assign dec_r = m - 8'd1;

	// Shift unit shared by the shift and combined operations
	always_comb begin
		case (instr.action)
			OP_ASL, OP_SLO: begin sh_c = m[7]; sh_r = {m[6:0], 1'b0}; end
			OP_LSR, OP_SRE: begin sh_c = m[0]; sh_r = {1'b0, m[7:1]}; end
			OP_ROL, OP_RLA: begin sh_c = m[7]; sh_r = {m[6:0], regs.p[FC]}; end
			default:        begin sh_c = m[0]; sh_r = {regs.p[FC], m[7:1]}; end
		endcase
	end

	// Accumulator as seen by a combined op after an accumulator-mode shift
	assign a_sh = instr.accumulator_mode ? sh_r : regs.a;

	// Adder operands
	always_comb begin
		adc_a   = regs.a;
		adc_cin = regs.p[FC];
		case (instr.action)
			OP_SBC:  adc_v = ~m;
			OP_ISB:  adc_v = ~inc_r;
			OP_RRA:  begin adc_v = sh_r; adc_a = a_sh; adc_cin = sh_c; end
			default: adc_v = m;
		endcase
	end
	assign adc_sum = {1'b0, adc_a} + {1'b0, adc_v} + {8'h00, adc_cin};

	// Comparator operands
	always_comb begin
		cmp_v = m;
		case (instr.action)
			OP_CPX:  cmp_reg = regs.x;
			OP_CPY:  cmp_reg = regs.y;
			OP_DCP:  begin cmp_reg = regs.a; cmp_v = dec_r; end
			default: cmp_reg = regs.a;
		endcase
	end
	assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_v};

	assign pc_lo = {pulled.b2, pulled.b1};

	// Decode and update
	always_comb begin
		regs_nx = regs;
		result  = '0;
		result.new_pc = instr.next_pc;
		isbr   = 1'b0;
		cond   = 1'b0;
		nzv    = 8'h00;
		set_nz = 1'b0;
		unique case (instr.action)
			OP_ADC, OP_SBC, OP_ISB, OP_RRA: begin
				regs_nx.a = adc_sum[7:0];
				regs_nx.p[FC] = adc_sum[8];
				regs_nx.p[FV] = (~(adc_a[7] ^ adc_v[7])) & (adc_a[7] ^ adc_sum[7]);
				nzv = adc_sum[7:0]; set_nz = 1'b1;
				if (instr.action == OP_ISB) begin
					result.mem_write = 1'b1; result.mem_data = inc_r;
				end
				if (instr.action == OP_RRA && !instr.accumulator_mode) begin
					result.mem_write = 1'b1; result.mem_data = sh_r;
				end
			end
			OP_AND: begin regs_nx.a = regs.a & m; nzv = regs.a & m; set_nz = 1'b1; end
			OP_EOR: begin regs_nx.a = regs.a ^ m; nzv = regs.a ^ m; set_nz = 1'b1; end
			OP_ORA: begin regs_nx.a = regs.a | m; nzv = regs.a | m; set_nz = 1'b1; end
			OP_ASL, OP_LSR, OP_ROL, OP_ROR: begin
				regs_nx.p[FC] = sh_c; nzv = sh_r; set_nz = 1'b1;
				if (instr.accumulator_mode) begin
					regs_nx.a = sh_r;
				end else begin
					result.mem_write = 1'b1; result.mem_data = sh_r;
				end
			end
			OP_SLO, OP_RLA, OP_SRE: begin
				regs_nx.p[FC] = sh_c; set_nz = 1'b1;
				if (!instr.accumulator_mode) begin
					result.mem_write = 1'b1; result.mem_data = sh_r;
				end
				case (instr.action)
					OP_SLO:  nzv = a_sh | sh_r;
					OP_RLA:  nzv = a_sh & sh_r;
					default: nzv = a_sh ^ sh_r;
				endcase
				regs_nx.a = nzv;
			end
			OP_BCC: begin isbr = 1'b1; cond = ~regs.p[FC]; end
			OP_BCS: begin isbr = 1'b1; cond = regs.p[FC]; end
			OP_BEQ: begin isbr = 1'b1; cond = regs.p[FZ]; end
			OP_BMI: begin isbr = 1'b1; cond = regs.p[FN]; end
			OP_BNE: begin isbr = 1'b1; cond = ~regs.p[FZ]; end
			OP_BPL: begin isbr = 1'b1; cond = ~regs.p[FN]; end
			OP_BVC: begin isbr = 1'b1; cond = ~regs.p[FV]; end
			OP_BVS: begin isbr = 1'b1; cond = regs.p[FV]; end
			OP_BIT: begin
				regs_nx.p[FZ] = (m & regs.a) == 8'h00;
				regs_nx.p[FV] = m[6];
				regs_nx.p[FN] = m[7];
			end
			OP_BRK: begin
				regs_nx.s = regs.s - 8'd1;
				regs_nx.p[FI] = 1'b1;
				regs_nx.p[FB] = 1'b1;
				result.new_pc = vector;
			end
			OP_CLC: regs_nx.p[FC] = 1'b0;
			OP_CLD: regs_nx.p[FD] = 1'b0;
			OP_CLI: regs_nx.p[FI] = 1'b0;
			OP_CLV: regs_nx.p[FV] = 1'b0;
			OP_SEC: regs_nx.p[FC] = 1'b1;
			OP_SED: regs_nx.p[FD] = 1'b1;
			OP_SEI: regs_nx.p[FI] = 1'b1;
			OP_CMP, OP_CPX, OP_CPY, OP_DCP: begin
				regs_nx.p[FC] = ~cmp_diff[8];
				regs_nx.p[FZ] = cmp_diff[7:0] == 8'h00;
				regs_nx.p[FN] = cmp_diff[7];
				if (instr.action == OP_DCP) begin
					result.mem_write = 1'b1; result.mem_data = dec_r;
				end
			end
			OP_DEC: begin result.mem_write = 1'b1; result.mem_data = dec_r;
				nzv = dec_r; set_nz = 1'b1; end
			OP_INC: begin result.mem_write = 1'b1; result.mem_data = inc_r;
				nzv = inc_r; set_nz = 1'b1; end
			OP_DEX: begin regs_nx.x = regs.x - 8'd1; nzv = regs.x - 8'd1; set_nz = 1'b1; end
			OP_DEY: begin regs_nx.y = regs.y - 8'd1; nzv = regs.y - 8'd1; set_nz = 1'b1; end
			OP_INX: begin regs_nx.x = regs.x + 8'd1; nzv = regs.x + 8'd1; set_nz = 1'b1; end
			OP_INY: begin regs_nx.y = regs.y + 8'd1; nzv = regs.y + 8'd1; set_nz = 1'b1; end
			OP_JMP: result.new_pc = instr.operand_address;
			OP_JSR: begin regs_nx.s = regs.s - 8'd1; result.new_pc = instr.operand_address; end
			OP_LDA: begin regs_nx.a = m; nzv = m; set_nz = 1'b1; end
			OP_LDX: begin regs_nx.x = m; nzv = m; set_nz = 1'b1; end
			OP_LDY: begin regs_nx.y = m; nzv = m; set_nz = 1'b1; end
			OP_LAX: begin regs_nx.a = m; regs_nx.x = m; nzv = m; set_nz = 1'b1; end
			OP_NOP: ;
			OP_PHA, OP_PHP: regs_nx.s = regs.s - 8'd1;
			OP_PLA: begin regs_nx.a = pulled.b2; nzv = pulled.b2; set_nz = 1'b1; end
			OP_PLP: regs_nx.p = (pulled.b2 & ~(8'h01 << FB)) | (8'h01 << FU);
			OP_RTI: begin
				regs_nx.p = (pulled.b0 & ~(8'h01 << FB)) | (8'h01 << FU);
				result.new_pc = pc_lo;
			end
			OP_RTS: result.new_pc = {pulled.b2, pulled.b0} + 16'd1;
			OP_STA: begin result.mem_write = 1'b1; result.mem_data = regs.a; end
			OP_STX: begin result.mem_write = 1'b1; result.mem_data = regs.x; end
			OP_STY: begin result.mem_write = 1'b1; result.mem_data = regs.y; end
			OP_SAX: begin result.mem_write = 1'b1; result.mem_data = regs.a & regs.x; end
			OP_TAX: begin regs_nx.x = regs.a; nzv = regs.a; set_nz = 1'b1; end
			OP_TAY: begin regs_nx.y = regs.a; nzv = regs.a; set_nz = 1'b1; end
			OP_TSX: begin regs_nx.x = regs.s; nzv = regs.s; set_nz = 1'b1; end
			OP_TXA: begin regs_nx.a = regs.x; nzv = regs.x; set_nz = 1'b1; end
			OP_TXS: regs_nx.s = regs.x;
			OP_TYA: begin regs_nx.a = regs.y; nzv = regs.y; set_nz = 1'b1; end
			default: ;
		endcase
		if (set_nz) begin
			regs_nx.p[FZ] = nzv == 8'h00;
			regs_nx.p[FN] = nzv[7];
		end
		if (result.mem_write) begin
			result.mem_address = instr.operand_address;
		end
		result.branch_taken = isbr & cond;
		result.extra_page_cycle = instr.page_crossed & (~isbr | cond);
		if (isbr && cond) begin
			result.new_pc = instr.operand_address;
		end
		result.acc_out           = regs_nx.a;
		result.x_out             = regs_nx.x;
		result.y_out             = regs_nx.y;
		result.stack_pointer_out = regs_nx.s;
		result.flags_out         = regs_nx.p;
	end

endmodule
`default_nettype wire

// ----- rtl/core/eight_bit_cpu_execute_unit.sv -----
// Execute unit of an 8-bit CPU: register file, stack sequencer and result register.
// Depends on ebc_pkg, ebc_stack_ram and ebc_alu.
//
// Usage:
//  - instr channel (valid/ready) carries one decoded instruction per transfer.
//  - result channel (valid/ready) returns exactly one result per instruction,
//    in order, from an output register.
//  - cfg channel (valid/ready, always ready) writes break_vector; write it
//    only while no instruction is in flight.
// Sequencing: each stack push (BRK 3, JSR 2, PHA/PHP 1) takes its own sequencer
// step, and each pull (PLA/PLP 1, RTS 2, RTI 3) a read step and a read-data step,
// as the stack memory read is registered; other instructions need a single step.
// The result is registered on the final step and is valid in the cycle after it.
// A new instruction is taken in the cycle the previous one finishes, so plain
// instructions sustain one per cycle while result_ready stays high.
// Reset: A=X=Y=0, S=0xFD, P=0x24, break_vector=0, stack page reads as zero.
// Stall: while result_ready is low and a result waits, the final step holds,
// and instr_ready drops once the sequencer is occupied.
`default_nettype none
module eight_bit_cpu_execute_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             instr_valid,
	output logic                  instr_ready,
	input  wire ebc_pkg::instr_t  instr,
	output logic                  result_valid,
	input  wire logic             result_ready,
	output ebc_pkg::result_t      result,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [15:0]      cfg_data
);
	import ebc_pkg::*;

	instr_t     item_q;
	logic       busy_q;
	logic [2:0] step_q;
	regs_t      regs_q;
	logic [15:0] vector_q;
	logic [7:0] b0_q;
	logic [7:0] b1_q;
	result_t    result_q;
	logic       result_valid_q;

	logic [1:0]  npush;
	logic [1:0]  npull;
	logic [2:0]  last_step;
	logic        final_step;
	logic        out_free;
	logic        fin;
	logic        advance;
	logic        push_we;
	logic [7:0]  push_data;
	logic        pull_re;
	logic [7:0]  rdata;
	logic [15:0] pc_plus;
	logic [15:0] pc_minus;
	pulled_t     pulled;
	regs_t       regs_nx;
	result_t     alu_result;

	assign npush = push_count(item_q.action);
	assign npull = pull_count(item_q.action);

	// Last sequencer step of the current instruction
	always_comb begin
		if (npull != 2'd0) begin
			last_step = {npull, 1'b0} - 3'd1;
		end else if (npush != 2'd0) begin
			last_step = {1'b0, npush} - 3'd1;
		end else begin
			last_step = 3'd0;
		end
	end

	assign final_step  = busy_q && (step_q == last_step);
	assign out_free    = !result_valid_q || result_ready;
	assign fin         = final_step && out_free;
	assign advance     = busy_q && !final_step;
	assign instr_ready = !busy_q || fin;
	assign cfg_ready   = 1'b1;

	// Select the pushed byte
	assign pc_plus  = item_q.next_pc + 16'd1;
	assign pc_minus = item_q.next_pc - 16'd1;
	always_comb begin
		push_data = regs_q.p | (8'h01 << FB) | (8'h01 << FU);
		case (item_q.action)
			OP_BRK: begin
				if (step_q == 3'd0) begin
					push_data = pc_plus[15:8];
				end else if (step_q == 3'd1) begin
					push_data = pc_plus[7:0];
				end
			end
			OP_JSR:  push_data = (step_q == 3'd0) ? pc_minus[15:8] : pc_minus[7:0];
			OP_PHA:  push_data = regs_q.a;
			default: ;
		endcase
	end

	assign push_we = (npush != 2'd0) && (advance || fin);
	assign pull_re = (npull != 2'd0) && busy_q && !step_q[0];

	ebc_stack_ram u_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (push_we),
		.waddr  (regs_q.s),
		.wdata  (push_data),
		.re     (pull_re),
		.raddr  (regs_q.s + 8'd1),
		.rdata  (rdata)
	);

	assign pulled.b0 = b0_q;
	assign pulled.b1 = b1_q;
	assign pulled.b2 = rdata;

	ebc_alu u_alu (
		.instr   (item_q),
		.regs    (regs_q),
		.pulled  (pulled),
		.vector  (vector_q),
		.regs_nx (regs_nx),
		.result  (alu_result)
	);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 3'd0;
		end else if (instr_valid && instr_ready) begin
			busy_q <= 1'b1;
			step_q <= 3'd0;
		end else if (fin) begin
			busy_q <= 1'b0;
		end else if (advance) begin
			step_q <= step_q + 3'd1;
		end
	end

	// Hold the instruction under execution
	always_ff @(posedge clk) begin
		if (instr_valid && instr_ready) begin
			item_q <= instr;
		end
	end

	// Capture pulled bytes on intermediate read-data steps
	always_ff @(posedge clk) begin
		if (advance && (npull != 2'd0) && step_q[0]) begin
			if (step_q == 3'd1) begin
				b0_q <= rdata;
			end else begin
				b1_q <= rdata;
			end
		end
	end

	// Register file and stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.a <= 8'h00;
			regs_q.x <= 8'h00;
			regs_q.y <= 8'h00;
			regs_q.s <= SP_RESET;
			regs_q.p <= P_RESET;
		end else if (fin) begin
			regs_q <= regs_nx;
		end else if (advance && (npush != 2'd0)) begin
			regs_q.s <= regs_q.s - 8'd1;
		end else if (pull_re) begin
			regs_q.s <= regs_q.s + 8'd1;
		end
	end

	// Break vector register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vector_q <= VECTOR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			vector_q <= cfg_data;
		end
	end

	// Output register: load on finish, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fin) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			result_q <= alu_result;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire
